### rtl/spit_pkg.sv
// ============================================================================
// spit_pkg - shared types and constants for the segment pair intersect test
// Widths, pipeline depth, register map and per-stage payload structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package spit_pkg;

    // Q16.16 coordinate and intermediate widths
    localparam int CRD_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int LINE_W  = 48;
    localparam int SUM_W   = 49;
    localparam int PROD_W  = 64;

    // Pipelined divider: one quotient bit per stage
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_STAGES = DIV_NUM_W;

    // Register map
    localparam int                 MARGIN_W        = 16;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET   = 16'd1;
    localparam int                 PADDR_W         = 3;
    localparam int                 PDATA_W         = 32;
    localparam logic               REG_EDGE_MARGIN = 1'b0;

    // Accept to result strobe, in clock edges
    localparam int PIPE_LATENCY = 2 * DIV_STAGES + 11;

    // Saturation bounds of the crossing x
    localparam logic signed [LINE_W-1:0] X_MAX = {1'b0, {(LINE_W-1){1'b1}}};
    localparam logic signed [LINE_W-1:0] X_MIN = {1'b1, {(LINE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [CRD_W-1:0] x0;
        logic signed [CRD_W-1:0] y0;
        logic signed [CRD_W-1:0] x1;
        logic signed [CRD_W-1:0] y1;
    } raw_seg_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] lo_x;
        logic signed [CRD_W-1:0] hi_x;
        logic signed [CRD_W-1:0] lo_y;
        logic signed [CRD_W-1:0] hi_y;
        logic signed [CRD_W-1:0] x0;
        logic signed [CRD_W-1:0] y0;
        logic                    vert;
    } seg_t;

    typedef struct packed {
        seg_t a;
        seg_t b;
    } pair_t;

    // What the final compare still needs after the crossing divide
    typedef struct packed {
        logic signed [CRD_W-1:0] a_lo_x;
        logic signed [CRD_W-1:0] a_hi_x;
        logic signed [CRD_W-1:0] b_lo_x;
        logic signed [CRD_W-1:0] b_hi_x;
        logic                    sloped;
        logic                    par;
        logic                    vhit;
    } tail_t;

    // Divide a Q32.32 product by 2^16, truncating toward zero
    function automatic logic signed [LINE_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p + $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{p[PROD_W-1]}}});
        return b[FRAC_W+LINE_W-1:FRAC_W];
    endfunction

endpackage

`default_nettype wire

### rtl/spit_div.sv
// ============================================================================
// spit_div - pipelined unsigned restoring divider
// One quotient bit per stage; a new division may enter every cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module spit_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [spit_pkg::DIV_NUM_W-1:0] in_num,
    input  wire logic [spit_pkg::DIV_DEN_W-1:0] in_den,
    input  wire logic                           in_neg,
    output logic                                out_valid,
    output logic [spit_pkg::DIV_NUM_W-1:0]      out_quo,
    output logic                                out_neg
);

    logic                           v_reg   [spit_pkg::DIV_STAGES];
    logic                           neg_reg [spit_pkg::DIV_STAGES];
    logic [spit_pkg::DIV_DEN_W-1:0] rem_reg [spit_pkg::DIV_STAGES];
    logic [spit_pkg::DIV_DEN_W-1:0] den_reg [spit_pkg::DIV_STAGES];
    logic [spit_pkg::DIV_NUM_W-1:0] nq_reg  [spit_pkg::DIV_STAGES];

    for (genvar i = 0; i < spit_pkg::DIV_STAGES; i++) begin : g_stage
        logic                           v_in;
        logic                           neg_in;
        logic [spit_pkg::DIV_DEN_W-1:0] rem_in;
        logic [spit_pkg::DIV_DEN_W-1:0] den_in;
        logic [spit_pkg::DIV_NUM_W-1:0] nq_in;
        logic [spit_pkg::DIV_DEN_W:0]   trial;
        logic [spit_pkg::DIV_DEN_W:0]   diff;
        logic                           ge;
        logic [spit_pkg::DIV_DEN_W-1:0] rem_next;
        logic [spit_pkg::DIV_NUM_W-1:0] nq_next;

        if (i == 0) begin : g_first
            assign v_in   = in_valid;
            assign neg_in = in_neg;
            assign rem_in = '0;
            assign den_in = in_den;
            assign nq_in  = in_num;
        end else begin : g_rest
            assign v_in   = v_reg[i-1];
            assign neg_in = neg_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign nq_in  = nq_reg[i-1];
        end

        // shift in next dividend bit, trial subtract
        always_comb
        begin
            trial    = {rem_in, nq_in[spit_pkg::DIV_NUM_W-1]};
            diff     = trial - {1'b0, den_in};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? diff[spit_pkg::DIV_DEN_W-1:0] : trial[spit_pkg::DIV_DEN_W-1:0];
            nq_next  = {nq_in[spit_pkg::DIV_NUM_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[i] <= neg_in;
            rem_reg[i] <= rem_next;
            den_reg[i] <= den_in;
            nq_reg[i]  <= nq_next;
        end
    end

    assign out_valid = v_reg[spit_pkg::DIV_STAGES-1];
    assign out_quo   = nq_reg[spit_pkg::DIV_STAGES-1];
    assign out_neg   = neg_reg[spit_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/segment_pair_intersect_test_unit.sv
// ============================================================================
// segment_pair_intersect_test_unit - strict crossing test of two segments
// Pipeline: two 64-stage bit-per-stage dividers (slopes, then crossing x) plus
// eleven arithmetic stages lie between start and done.
// Throughput: one transfer per cycle; busy is always low, results never stall.
// Reset: rst_n clears all valid bits at once; edge_margin returns to 1.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module segment_pair_intersect_test_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [31:0]             seg_a_x0,
    input  wire logic signed [31:0]             seg_a_y0,
    input  wire logic signed [31:0]             seg_a_x1,
    input  wire logic signed [31:0]             seg_a_y1,
    input  wire logic signed [31:0]             seg_b_x0,
    input  wire logic signed [31:0]             seg_b_y0,
    input  wire logic signed [31:0]             seg_b_x1,
    input  wire logic signed [31:0]             seg_b_y1,
    output logic                                done,
    output logic                                crosses,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [spit_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [spit_pkg::PDATA_W-1:0]   pwdata,
    output logic [spit_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int CW = spit_pkg::CRD_W;
    localparam int LW = spit_pkg::LINE_W;
    localparam int SW = spit_pkg::SUM_W;
    localparam int PW = spit_pkg::PROD_W;
    localparam int NW = spit_pkg::DIV_NUM_W;
    localparam int DW = spit_pkg::DIV_DEN_W;
    localparam int FW = spit_pkg::FRAC_W;
    localparam int MW = spit_pkg::MARGIN_W;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [MW-1:0] margin_reg;
    logic          cfg_sel;

    assign cfg_sel = (paddr[spit_pkg::PADDR_W-1] == spit_pkg::REG_EDGE_MARGIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= spit_pkg::MARGIN_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            margin_reg <= pwdata[MW-1:0];
        end
    end

    assign prdata = cfg_sel ? {{(spit_pkg::PDATA_W-MW){1'b0}}, margin_reg} : '0;

    // ------------------------------------------------------------------
    // Valid chain (control state, reset)
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic done_reg;
    logic dva_valid [2];
    logic dvb_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= dva_valid[0] && dva_valid[1];
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= dvb_valid;
            done_reg <= v9_reg;
        end
    end

    // ------------------------------------------------------------------
    // P0: capture inputs
    // ------------------------------------------------------------------
    spit_pkg::raw_seg_t p0_raw_reg [2];

    always_ff @(posedge clk)
    begin
        p0_raw_reg[0] <= '{x0: seg_a_x0, y0: seg_a_y0, x1: seg_a_x1, y1: seg_a_y1};
        p0_raw_reg[1] <= '{x0: seg_b_x0, y0: seg_b_y0, x1: seg_b_x1, y1: seg_b_y1};
    end

    // ------------------------------------------------------------------
    // P1: deltas, bounding box, vertical flag
    // ------------------------------------------------------------------
    spit_pkg::seg_t   p1_seg_next [2];
    logic signed [CW:0] p1_dx_next [2];
    logic signed [CW:0] p1_dy_next [2];
    spit_pkg::seg_t   p1_seg_reg  [2];
    logic signed [CW:0] p1_dx_reg  [2];
    logic signed [CW:0] p1_dy_reg  [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            p1_dx_next[i] = $signed({p0_raw_reg[i].x1[CW-1], p0_raw_reg[i].x1})
                          - $signed({p0_raw_reg[i].x0[CW-1], p0_raw_reg[i].x0});
            p1_dy_next[i] = $signed({p0_raw_reg[i].y1[CW-1], p0_raw_reg[i].y1})
                          - $signed({p0_raw_reg[i].y0[CW-1], p0_raw_reg[i].y0});
            if (p0_raw_reg[i].x0 < p0_raw_reg[i].x1)
            begin
                p1_seg_next[i].lo_x = p0_raw_reg[i].x0;
                p1_seg_next[i].hi_x = p0_raw_reg[i].x1;
            end
            else
            begin
                p1_seg_next[i].lo_x = p0_raw_reg[i].x1;
                p1_seg_next[i].hi_x = p0_raw_reg[i].x0;
            end
            if (p0_raw_reg[i].y0 < p0_raw_reg[i].y1)
            begin
                p1_seg_next[i].lo_y = p0_raw_reg[i].y0;
                p1_seg_next[i].hi_y = p0_raw_reg[i].y1;
            end
            else
            begin
                p1_seg_next[i].lo_y = p0_raw_reg[i].y1;
                p1_seg_next[i].hi_y = p0_raw_reg[i].y0;
            end
            p1_seg_next[i].x0   = p0_raw_reg[i].x0;
            p1_seg_next[i].y0   = p0_raw_reg[i].y0;
            p1_seg_next[i].vert = (p0_raw_reg[i].x0 == p0_raw_reg[i].x1);
        end
    end

    always_ff @(posedge clk)
    begin
        p1_seg_reg <= p1_seg_next;
        p1_dx_reg  <= p1_dx_next;
        p1_dy_reg  <= p1_dy_next;
    end

    // ------------------------------------------------------------------
    // P2: slope divider operands (magnitudes and sign)
    // ------------------------------------------------------------------
    logic [NW-1:0] p2_num_next [2];
    logic [DW-1:0] p2_den_next [2];
    logic          p2_neg_next [2];
    logic [NW-1:0] p2_num_reg  [2];
    logic [DW-1:0] p2_den_reg  [2];
    logic          p2_neg_reg  [2];
    spit_pkg::pair_t p2_pair_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            logic [CW:0] ady;
            logic [CW:0] adx;
            ady = p1_dy_reg[i][CW] ? 33'(-p1_dy_reg[i]) : 33'(p1_dy_reg[i]);
            adx = p1_dx_reg[i][CW] ? 33'(-p1_dx_reg[i]) : 33'(p1_dx_reg[i]);
            p2_num_next[i] = {{(NW-CW-FW){1'b0}}, ady[CW-1:0], {FW{1'b0}}};
            p2_den_next[i] = adx[DW-1:0];
            p2_neg_next[i] = p1_dy_reg[i][CW] ^ p1_dx_reg[i][CW];
        end
    end

    always_ff @(posedge clk)
    begin
        p2_num_reg  <= p2_num_next;
        p2_den_reg  <= p2_den_next;
        p2_neg_reg  <= p2_neg_next;
        p2_pair_reg <= '{a: p1_seg_reg[0], b: p1_seg_reg[1]};
    end

    // ------------------------------------------------------------------
    // Slope dividers and matching delay line
    // ------------------------------------------------------------------
    logic [NW-1:0] dva_quo [2];
    logic          dva_neg [2];

    for (genvar g = 0; g < 2; g++) begin : g_slope
        spit_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v2_reg),
            .in_num    (p2_num_reg[g]),
            .in_den    (p2_den_reg[g]),
            .in_neg    (p2_neg_reg[g]),
            .out_valid (dva_valid[g]),
            .out_quo   (dva_quo[g]),
            .out_neg   (dva_neg[g])
        );
    end

    spit_pkg::pair_t dla_reg [spit_pkg::DIV_STAGES];

    always_ff @(posedge clk)
    begin
        dla_reg[0] <= p2_pair_reg;
        for (int i = 1; i < spit_pkg::DIV_STAGES; i++)
        begin
            dla_reg[i] <= dla_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // P3: saturate slopes to Q16.16
    // ------------------------------------------------------------------
    logic signed [CW-1:0] p3_k_next [2];
    logic signed [CW-1:0] p3_k_reg  [2];
    spit_pkg::pair_t      p3_pair_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (!dva_neg[i])
            begin
                if (|dva_quo[i][NW-1:CW-1])
                    p3_k_next[i] = {1'b0, {(CW-1){1'b1}}};
                else
                    p3_k_next[i] = $signed(dva_quo[i][CW-1:0]);
            end
            else
            begin
                if ((|dva_quo[i][NW-1:CW]) || (dva_quo[i][CW-1] && |dva_quo[i][CW-2:0]))
                    p3_k_next[i] = {1'b1, {(CW-1){1'b0}}};
                else
                    p3_k_next[i] = $signed(-dva_quo[i][CW-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p3_k_reg    <= p3_k_next;
        p3_pair_reg <= dla_reg[spit_pkg::DIV_STAGES-1];
    end

    // ------------------------------------------------------------------
    // P4: k*x0 per segment, sloped k at the vertical x
    // ------------------------------------------------------------------
    logic signed [PW-1:0] p4_pc_reg [2];
    logic signed [PW-1:0] p4_py_reg;
    logic signed [CW-1:0] p4_k_reg  [2];
    spit_pkg::pair_t      p4_pair_reg;
    logic signed [CW-1:0] p4_ks;
    logic signed [CW-1:0] p4_xv;

    assign p4_ks = p3_pair_reg.a.vert ? p3_k_reg[1] : p3_k_reg[0];
    assign p4_xv = p3_pair_reg.a.vert ? p3_pair_reg.a.x0 : p3_pair_reg.b.x0;

    always_ff @(posedge clk)
    begin
        p4_pc_reg[0] <= PW'(p3_k_reg[0]) * PW'(p3_pair_reg.a.x0);
        p4_pc_reg[1] <= PW'(p3_k_reg[1]) * PW'(p3_pair_reg.b.x0);
        p4_py_reg    <= PW'(p4_ks) * PW'(p4_xv);
        p4_k_reg     <= p3_k_reg;
        p4_pair_reg  <= p3_pair_reg;
    end

    // ------------------------------------------------------------------
    // P5: truncating divide of products by 2^16
    // ------------------------------------------------------------------
    logic signed [LW-1:0] p5_tc_reg [2];
    logic signed [LW-1:0] p5_ty_reg;
    logic signed [CW-1:0] p5_k_reg  [2];
    spit_pkg::pair_t      p5_pair_reg;

    always_ff @(posedge clk)
    begin
        p5_tc_reg[0] <= spit_pkg::trunc_q16(p4_pc_reg[0]);
        p5_tc_reg[1] <= spit_pkg::trunc_q16(p4_pc_reg[1]);
        p5_ty_reg    <= spit_pkg::trunc_q16(p4_py_reg);
        p5_k_reg     <= p4_k_reg;
        p5_pair_reg  <= p4_pair_reg;
    end

    // ------------------------------------------------------------------
    // P6: intercepts, slope difference
    // ------------------------------------------------------------------
    logic signed [LW-1:0] p6_c_reg [2];
    logic signed [LW-1:0] p6_ty_reg;
    logic signed [CW:0]   p6_dk_reg;
    logic                 p6_par_reg;
    spit_pkg::pair_t      p6_pair_reg;

    always_ff @(posedge clk)
    begin
        p6_c_reg[0] <= $signed({{(LW-CW){p5_pair_reg.a.y0[CW-1]}}, p5_pair_reg.a.y0})
                     - p5_tc_reg[0];
        p6_c_reg[1] <= $signed({{(LW-CW){p5_pair_reg.b.y0[CW-1]}}, p5_pair_reg.b.y0})
                     - p5_tc_reg[1];
        p6_dk_reg   <= $signed({p5_k_reg[0][CW-1], p5_k_reg[0]})
                     - $signed({p5_k_reg[1][CW-1], p5_k_reg[1]});
        p6_par_reg  <= (p5_k_reg[0] == p5_k_reg[1]);
        p6_ty_reg   <= p5_ty_reg;
        p6_pair_reg <= p5_pair_reg;
    end

    // ------------------------------------------------------------------
    // P7: clamped intercept difference, sloped y at the vertical x
    // ------------------------------------------------------------------
    logic signed [SW-1:0] p7_dfull;
    logic signed [SW-1:0] p7_y_next;
    logic signed [LW-1:0] p7_cs;
    logic signed [LW-1:0] p7_d_next;
    logic signed [LW-1:0] p7_d_reg;
    logic signed [SW-1:0] p7_y_reg;
    logic signed [CW:0]   p7_dk_reg;
    logic                 p7_par_reg;
    spit_pkg::pair_t      p7_pair_reg;

    always_comb
    begin
        p7_dfull = $signed({p6_c_reg[1][LW-1], p6_c_reg[1]})
                 - $signed({p6_c_reg[0][LW-1], p6_c_reg[0]});
        if (p7_dfull > $signed({{(SW-LW+1){1'b0}}, {(LW-1){1'b1}}}))
            p7_d_next = {1'b0, {(LW-1){1'b1}}};
        else if (p7_dfull < -$signed({{(SW-LW+1){1'b0}}, {(LW-1){1'b1}}}))
            p7_d_next = {1'b1, {(LW-2){1'b0}}, 1'b1};
        else
            p7_d_next = p7_dfull[LW-1:0];
        p7_cs     = p6_pair_reg.a.vert ? p6_c_reg[1] : p6_c_reg[0];
        p7_y_next = $signed({p6_ty_reg[LW-1], p6_ty_reg}) + $signed({p7_cs[LW-1], p7_cs});
    end

    always_ff @(posedge clk)
    begin
        p7_d_reg    <= p7_d_next;
        p7_y_reg    <= p7_y_next;
        p7_dk_reg   <= p6_dk_reg;
        p7_par_reg  <= p6_par_reg;
        p7_pair_reg <= p6_pair_reg;
    end

    // ------------------------------------------------------------------
    // P8: vertical-case result, crossing divider operands
    // ------------------------------------------------------------------
    spit_pkg::seg_t  p8_v;
    spit_pkg::seg_t  p8_s;
    logic            p8_vv;
    logic            p8_vs;
    logic [LW-1:0]   p8_dmag;
    logic [CW:0]     p8_dkmag;
    spit_pkg::tail_t p8_tail_next;
    logic [NW-1:0]   p8_num_reg;
    logic [DW-1:0]   p8_den_reg;
    logic            p8_neg_reg;
    spit_pkg::tail_t p8_tail_reg;

    always_comb
    begin
        p8_v  = p7_pair_reg.a.vert ? p7_pair_reg.a : p7_pair_reg.b;
        p8_s  = p7_pair_reg.a.vert ? p7_pair_reg.b : p7_pair_reg.a;
        p8_vv = (p7_pair_reg.a.x0 == p7_pair_reg.b.x0)
             && (p7_pair_reg.a.hi_y > p7_pair_reg.b.lo_y)
             && (p7_pair_reg.a.lo_y < p7_pair_reg.b.hi_y);
        p8_vs = (p8_v.lo_x < p8_s.hi_x) && (p8_v.hi_x > p8_s.lo_x)
             && (p7_y_reg < $signed({{(SW-CW){p8_v.hi_y[CW-1]}}, p8_v.hi_y}))
             && (p7_y_reg > $signed({{(SW-CW){p8_v.lo_y[CW-1]}}, p8_v.lo_y}));
        p8_dmag  = p7_d_reg[LW-1] ? LW'(-p7_d_reg) : LW'(p7_d_reg);
        p8_dkmag = p7_dk_reg[CW] ? 33'(-p7_dk_reg) : 33'(p7_dk_reg);
        p8_tail_next.a_lo_x = p7_pair_reg.a.lo_x;
        p8_tail_next.a_hi_x = p7_pair_reg.a.hi_x;
        p8_tail_next.b_lo_x = p7_pair_reg.b.lo_x;
        p8_tail_next.b_hi_x = p7_pair_reg.b.hi_x;
        p8_tail_next.sloped = !p7_pair_reg.a.vert && !p7_pair_reg.b.vert;
        p8_tail_next.par    = p7_par_reg;
        p8_tail_next.vhit   = (p7_pair_reg.a.vert && p7_pair_reg.b.vert) ? p8_vv : p8_vs;
    end

    always_ff @(posedge clk)
    begin
        p8_num_reg  <= {{(NW-LW-FW+1){1'b0}}, p8_dmag[LW-2:0], {FW{1'b0}}};
        p8_den_reg  <= p8_dkmag[DW-1:0];
        p8_neg_reg  <= p7_d_reg[LW-1] ^ p7_dk_reg[CW];
        p8_tail_reg <= p8_tail_next;
    end

    // ------------------------------------------------------------------
    // Crossing-x divider and matching delay line
    // ------------------------------------------------------------------
    logic [NW-1:0] dvb_quo;
    logic          dvb_neg;

    spit_div u_cross_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v8_reg),
        .in_num    (p8_num_reg),
        .in_den    (p8_den_reg),
        .in_neg    (p8_neg_reg),
        .out_valid (dvb_valid),
        .out_quo   (dvb_quo),
        .out_neg   (dvb_neg)
    );

    spit_pkg::tail_t dlb_reg [spit_pkg::DIV_STAGES];

    always_ff @(posedge clk)
    begin
        dlb_reg[0] <= p8_tail_reg;
        for (int i = 1; i < spit_pkg::DIV_STAGES; i++)
        begin
            dlb_reg[i] <= dlb_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // P9: saturate crossing x to 48 bits
    // ------------------------------------------------------------------
    logic signed [LW-1:0] p9_x_next;
    logic signed [LW-1:0] p9_x_reg;
    spit_pkg::tail_t      p9_tail_reg;

    always_comb
    begin
        if (!dvb_neg)
        begin
            if (|dvb_quo[NW-1:LW-1])
                p9_x_next = spit_pkg::X_MAX;
            else
                p9_x_next = $signed(dvb_quo[LW-1:0]);
        end
        else
        begin
            if ((|dvb_quo[NW-1:LW]) || (dvb_quo[LW-1] && |dvb_quo[LW-2:0]))
                p9_x_next = spit_pkg::X_MIN;
            else
                p9_x_next = $signed(-dvb_quo[LW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        p9_x_reg    <= p9_x_next;
        p9_tail_reg <= dlb_reg[spit_pkg::DIV_STAGES-1];
    end

    // ------------------------------------------------------------------
    // P10: margin-shrunk x range compares or vertical flag, result register
    // ------------------------------------------------------------------
    logic signed [CW+1:0] a_lo_m, a_hi_m, b_lo_m, b_hi_m;
    logic signed [CW+1:0] m_ext;
    logic                 hit;

    always_comb
    begin
        m_ext  = $signed({{(CW+2-MW){1'b0}}, margin_reg});
        a_lo_m = $signed({{2{p9_tail_reg.a_lo_x[CW-1]}}, p9_tail_reg.a_lo_x}) + m_ext;
        a_hi_m = $signed({{2{p9_tail_reg.a_hi_x[CW-1]}}, p9_tail_reg.a_hi_x}) - m_ext;
        b_lo_m = $signed({{2{p9_tail_reg.b_lo_x[CW-1]}}, p9_tail_reg.b_lo_x}) + m_ext;
        b_hi_m = $signed({{2{p9_tail_reg.b_hi_x[CW-1]}}, p9_tail_reg.b_hi_x}) - m_ext;
        if (p9_tail_reg.sloped)
            hit = !p9_tail_reg.par
               && (p9_x_reg > $signed({{(LW-CW-2){a_lo_m[CW+1]}}, a_lo_m}))
               && (p9_x_reg < $signed({{(LW-CW-2){a_hi_m[CW+1]}}, a_hi_m}))
               && (p9_x_reg > $signed({{(LW-CW-2){b_lo_m[CW+1]}}, b_lo_m}))
               && (p9_x_reg < $signed({{(LW-CW-2){b_hi_m[CW+1]}}, b_hi_m}));
        else
            hit = p9_tail_reg.vhit;
    end

    logic crosses_reg;

    always_ff @(posedge clk)
    begin
        crosses_reg <= hit;
    end

    assign done    = done_reg;
    assign crosses = crosses_reg;

endmodule

`default_nettype wire

### rtl/spit_chk.sv
// ============================================================================
// spit_chk - port-level checker for the segment intersect unit
// Fixed-latency result strobe, no spurious results, always-ready ports.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module spit_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic pready
);

    // every accepted transfer yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(spit_pkg::PIPE_LATENCY) done)
        else $error("result missing after accepted transfer");

    // no result without a matching accepted transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, spit_pkg::PIPE_LATENCY))
        else $error("result without accepted transfer");

    // pipeline never pushes back
    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind segment_pair_intersect_test_unit spit_chk u_spit_chk (.*);

`default_nettype wire

### test/testbench.sv
// ============================================================================
// testbench - segment pair intersect test unit
// Drives segment pairs through the command port, predicts the strict crossing
// flag with a fixed-point model kept here, and checks every result strobe.
// The edge margin register is changed between phases while the unit is idle.
// ============================================================================
`timescale 1ns / 1ps

class crossing_scoreboard;
    bit  pending_cross[$];
    int  error_count;

    function void note_pair(bit hit);
        pending_cross.push_back(hit);
    endfunction

    function void check_result(bit got);
        bit want;
        if (pending_cross.size() == 0) begin
            $error("crosses: no result expected, actual %0d", got);
            error_count++;
        end else begin
            want = pending_cross.pop_front();
            if (want !== got) begin
                $error("crosses: expected %0d, actual %0d", want, got);
                error_count++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint SLOPE_HI = 64'sd2147483647;
    localparam longint SLOPE_LO = -64'sd2147483648;
    localparam longint W48_HI   = 64'sd140737488355327;
    localparam longint W48_LO   = -64'sd140737488355328;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1;
    logic signed [31:0] seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1;
    logic done;
    logic crosses;
    logic psel, penable, pwrite;
    logic [spit_pkg::PADDR_W-1:0] paddr;
    logic [spit_pkg::PDATA_W-1:0] pwdata;
    logic [spit_pkg::PDATA_W-1:0] prdata;
    logic pready;

    crossing_scoreboard board;
    longint margin_now;
    int idle_cycles;
    bit timed_out;

    typedef struct {
        longint lo_x, hi_x, lo_y, hi_y, x0, k, c;
        bit vert;
    } line_t;

    segment_pair_intersect_test_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .seg_a_x0(seg_a_x0), .seg_a_y0(seg_a_y0),
        .seg_a_x1(seg_a_x1), .seg_a_y1(seg_a_y1),
        .seg_b_x0(seg_b_x0), .seg_b_y0(seg_b_y0),
        .seg_b_x1(seg_b_x1), .seg_b_y1(seg_b_y1),
        .done(done), .crosses(crosses),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // slope and intercept of one segment; SV division truncates toward zero
    function automatic line_t build_line(longint x0, longint y0, longint x1, longint y1);
        line_t s;
        longint dx, dy;
        dx = x1 - x0;
        dy = y1 - y0;
        s.lo_x = x0 < x1 ? x0 : x1;
        s.hi_x = x0 < x1 ? x1 : x0;
        s.lo_y = y0 < y1 ? y0 : y1;
        s.hi_y = y0 < y1 ? y1 : y0;
        s.x0 = x0;
        s.k = 0;
        s.c = 0;
        s.vert = (dx == 0);
        if (!s.vert) begin
            s.k = clip((dy * 65536) / dx, SLOPE_LO, SLOPE_HI);
            s.c = y0 - (s.k * x0) / 65536;
        end
        return s;
    endfunction

    // vertical segment against a sloped one
    function automatic bit vertical_hits(line_t v, line_t s);
        longint y;
        y = (s.k * v.x0) / 65536 + s.c;
        return v.lo_x < s.hi_x && v.hi_x > s.lo_x && y < v.hi_y && y > v.lo_y;
    endfunction

    function automatic bit predict_crossing(logic signed [31:0] p [8]);
        line_t a, b;
        longint d, x, m;
        a = build_line(p[0], p[1], p[2], p[3]);
        b = build_line(p[4], p[5], p[6], p[7]);
        m = margin_now;
        if (!a.vert && !b.vert) begin
            if (a.k == b.k) return 0;
            d = clip(b.c - a.c, -W48_HI, W48_HI);
            x = clip((d * 65536) / (a.k - b.k), W48_LO, W48_HI);
            return x > a.lo_x + m && x < a.hi_x - m && x > b.lo_x + m && x < b.hi_x - m;
        end
        if (a.vert && !b.vert) return vertical_hits(a, b);
        if (!a.vert && b.vert) return vertical_hits(b, a);
        return a.x0 == b.x0 && a.hi_y > b.lo_y && a.lo_y < b.hi_y;
    endfunction

    // result monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (done) board.check_result(crosses);
            if ((start && !busy) || done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1;
        $display("testbench: errors");
        $finish;
    end

    task automatic write_margin(int unsigned value);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1;
        paddr = spit_pkg::PADDR_W'(spit_pkg::REG_EDGE_MARGIN) << 2;
        pwdata = value;
        @(negedge clk);
        penable = 1;
        do @(posedge clk); while (!pready);
        margin_now = value & 32'hFFFF;
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // wait until every expected result has arrived, plus the pipeline drain
    task automatic drain();
        @(negedge clk);
        start = 0;
        while (board.pending_cross.size() != 0) @(posedge clk);
        repeat (spit_pkg::PIPE_LATENCY + 5) @(posedge clk);
    endtask

    // one transfer; start held high across back-to-back pairs
    task automatic send_pair(logic signed [31:0] p [8], bit keep_going);
        @(negedge clk);
        {seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1} = {p[0], p[1], p[2], p[3]};
        {seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1} = {p[4], p[5], p[6], p[7]};
        start = 1;
        do @(posedge clk); while (busy);
        board.note_pair(predict_crossing(p));
        if (!keep_going) begin
            @(negedge clk);
            start = 0;
        end
    endtask

    function automatic logic signed [31:0] rand_coord(int scale);
        case (scale)
            0: return $signed($urandom_range(0, 400)) - 200;
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: return $urandom;
            default: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // random pair: mostly crossing-prone shapes built around a shared point
    function automatic void random_pair(output logic signed [31:0] p [8]);
        int scale, shape;
        logic signed [31:0] cx, cy;
        scale = $urandom_range(0, 9) < 5 ? 1 : $urandom_range(0, 3);
        shape = $urandom_range(0, 9);
        foreach (p[i]) p[i] = rand_coord(scale);
        cx = rand_coord(scale) >>> 1;
        cy = rand_coord(scale) >>> 1;
        case (shape) inside
            [0:3]: begin
                // mirror endpoints through a common point
                p[2] = 2 * cx - p[0]; p[3] = 2 * cy - p[1];
                p[6] = 2 * cx - p[4]; p[7] = 2 * cy - p[5];
            end
            4: begin p[2] = p[0]; p[4] = 2 * cx - p[0]; p[6] = p[0]; end
            5: begin p[2] = p[0]; p[3] = 2 * cy - p[1]; p[6] = 2 * cx - p[4]; end
            6: begin p[6] = p[4]; p[5] = 2 * cy - p[7]; p[2] = 2 * cx - p[0]; end
            7: begin
                // parallel copy shifted in y
                p[4] = p[0]; p[6] = p[2];
                p[5] = p[1] + cy; p[7] = p[3] + cy;
            end
            8: begin p[2] = p[0]; p[3] = p[1]; end
            default: ;
        endcase
    endfunction

    task automatic random_phase(int count);
        logic signed [31:0] p [8];
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && sent < count; j++) begin
                random_pair(p);
                send_pair(p, j != burst - 1 && sent != count - 1);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic directed_pairs();
        logic signed [31:0] p [8];
        logic signed [31:0] mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        // plain X crossing
        p = '{-65536, -65536, 65536, 65536, -65536, 65536, 65536, -65536};
        send_pair(p, 1);
        // parallel, and collinear overlapping
        p = '{0, 0, 65536, 65536, 0, 100, 65536, 65636};
        send_pair(p, 1);
        p = '{0, 0, 131072, 131072, 65536, 65536, 196608, 196608};
        send_pair(p, 1);
        // vertical against sloped, both orders
        p = '{0, -65536, 0, 65536, -65536, 0, 65536, 0};
        send_pair(p, 1);
        p = '{-65536, 0, 65536, 0, 0, -65536, 0, 65536};
        send_pair(p, 1);
        // two verticals: same x overlapping, same x touching end to end, different x
        p = '{5, 0, 5, 100, 5, 50, 5, 200};
        send_pair(p, 1);
        p = '{5, 0, 5, 100, 5, 100, 5, 200};
        send_pair(p, 1);
        p = '{5, 0, 5, 100, 6, 50, 6, 200};
        send_pair(p, 1);
        // degenerate points
        p = '{7, 7, 7, 7, -65536, -65536, 65536, 65536};
        send_pair(p, 1);
        p = '{0, 0, 0, 0, 0, 0, 0, 0};
        send_pair(p, 1);
        // extreme slopes saturate
        p = '{0, mn, 1, mx, -1, 0, 2, 0};
        send_pair(p, 1);
        p = '{0, mx, 1, mn, -1, 0, 2, 0};
        send_pair(p, 1);
        // full-range coordinates
        p = '{mn, mn, mx, mx, mn, mx, mx, mn};
        send_pair(p, 1);
        p = '{mx, mn, mn, mx, mx, mx, mn, mn};
        send_pair(p, 1);
        p = '{-1, -1, 1, 1, -1, 1, 1, -1};
        send_pair(p, 1);
        p = '{mn, 0, mx, 0, 0, mn, 0, mx};
        send_pair(p, 0);
    endtask

    initial begin
        board = new();
        clk = 0;
        rst_n = 0;
        start = 0;
        {seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1} = '0;
        {seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1} = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        margin_now = spit_pkg::MARGIN_RESET;
        idle_cycles = 0;
        timed_out = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;

        // reset margin, then each margin setting incl. the extremes
        directed_pairs();
        random_phase(300);
        drain();
        write_margin(0);
        directed_pairs();
        random_phase(450);
        drain();
        write_margin(16'hFFFF);
        directed_pairs();
        random_phase(300);
        drain();
        write_margin($urandom_range(2, 16'hFFFE));
        random_phase(300);
        drain();
        write_margin(32'hFFFF_0000 | $urandom_range(0, 300));
        random_phase(300);
        drain();

        if (!timed_out) begin
            if (board.error_count == 0)
                $display("testbench: clean");
            else
                $display("testbench: errors");
            $finish;
        end
    end
endmodule
